>>> rtl/core/lpc_pkg.sv
// Package for the lidar point level-and-crop block.
// Holds the register map, the fixed field widths and the register reset values.
// No dependencies.
`default_nettype none

package lpc_pkg;

	// Fixed widths of the packed coefficient and offset fields.
	localparam int COEFF_W  = 18;
	localparam int OFFSET_W = 20;

	// Register widths.
	localparam int ROW_W    = 3 * COEFF_W;
	localparam int OFFS_W   = 3 * OFFSET_W;
	localparam int RADIUS_W = 36;
	localparam int RANGE_W  = 38;

	// Configuration bus.
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;

	typedef enum logic [2:0] {
		REG_ROW_X     = 3'd0,
		REG_ROW_Y     = 3'd1,
		REG_ROW_Z     = 3'd2,
		REG_OFFSET    = 3'd3,
		REG_RADIUS    = 3'd4,
		REG_MIN_RANGE = 3'd5,
		REG_MAX_RANGE = 3'd6
	} reg_idx_t;

	// Reset values: identity matrix at 16 fraction bits, no offset, default limits.
	localparam logic [ROW_W-1:0]    ROW_X_RESET     = 54'd65536;
	localparam logic [ROW_W-1:0]    ROW_Y_RESET     = 54'd17179869184;
	localparam logic [ROW_W-1:0]    ROW_Z_RESET     = 54'd4503599627370496;
	localparam logic [OFFS_W-1:0]   OFFSET_RESET    = 60'd0;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 36'd4000000;
	localparam logic [RANGE_W-1:0]  MIN_RANGE_RESET = 38'd0;
	localparam logic [RANGE_W-1:0]  MAX_RANGE_RESET = 38'd2500000000;

endpackage

`default_nettype wire

>>> rtl/core/lidar_point_level_and_crop.sv
// Top level of the lidar point level-and-crop block: five-stage point pipeline
// and its APB configuration registers. Depends on lpc_pkg.
//
// Usage. Points enter on the s_axis channel, one item per point; results leave
// on the m_axis channel, exactly one item per point, in order. Each point is
// multiplied by the 3x3 matrix in the row registers, shifted by the offset,
// rounded to whole millimetres and saturated, and then tested against the
// landing cylinder and the range shell. A point without the finite flag comes
// out with zero coordinates and is never kept.
// Stages: products, row sum, round and saturate, squares, region test.
// Throughput is one item per cycle while the receiver does not stall; the
// rate is set by the nine multipliers of the first stage and the three
// squarers of the fourth, each used once per item. When the receiver stalls,
// the result waits in the output stage and the stages behind it keep filling;
// s_axis_tready drops only once every stage holds an item. Reset empties the
// pipeline and loads the identity matrix, zero offset and the default limits.
// Configuration is written over APB with 64-bit data, register i at byte
// address 8*i; the user must do so only while the block is idle (unenforced).
`default_nettype none

module lidar_point_level_and_crop #(
	parameter int COORD_BITS      = 19,
	parameter int COEFF_FRAC_BITS = 16,
	localparam int IN_DATA_W      = ((3 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W     = ((3 * COORD_BITS + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input points.
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]              s_axis_tdata,  // point_x, point_y, point_z
	input  wire logic                              s_axis_tuser,  // point_finite
	input  wire logic                              s_axis_tlast,  // frame_end
	// Results.
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output      logic [OUT_DATA_W-1:0]             m_axis_tdata,  // level_x, level_y, level_z
	output      logic                              m_axis_tuser,  // inside_res
	output      logic                              m_axis_tlast,  // last_point
	// Configuration.
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lpc_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [lpc_pkg::CFG_DATA_W-1:0]    pwdata,
	output      logic [lpc_pkg::CFG_DATA_W-1:0]    prdata,
	output      logic                              pready
);
	import lpc_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int F      = COEFF_FRAC_BITS;
	localparam int PROD_W = C + COEFF_W;
	localparam int OFSH_W = OFFSET_W + F;
	localparam int BASE_W = (PROD_W > OFSH_W) ? PROD_W : OFSH_W;
	localparam int MAXB_W = (BASE_W > C + F) ? BASE_W : C + F;
	localparam int ACC_W  = MAXB_W + 2;
	localparam int SH_W   = ACC_W - F;
	localparam int SQ_W   = 2 * C;
	localparam int CMP_W  = (SQ_W + 2 > RANGE_W) ? SQ_W + 2 : RANGE_W;
	localparam int PAD_W  = OUT_DATA_W - 3 * C;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ROW_W-1:0]    row_q [3];
	logic [OFFS_W-1:0]   offset_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [RANGE_W-1:0]  min_range_q;
	logic [RANGE_W-1:0]  max_range_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]    <= ROW_X_RESET;
			row_q[1]    <= ROW_Y_RESET;
			row_q[2]    <= ROW_Z_RESET;
			offset_q    <= OFFSET_RESET;
			radius_q    <= RADIUS_RESET;
			min_range_q <= MIN_RANGE_RESET;
			max_range_q <= MAX_RANGE_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ROW_X:     row_q[0]    <= pwdata[ROW_W-1:0];
				REG_ROW_Y:     row_q[1]    <= pwdata[ROW_W-1:0];
				REG_ROW_Z:     row_q[2]    <= pwdata[ROW_W-1:0];
				REG_OFFSET:    offset_q    <= pwdata[OFFS_W-1:0];
				REG_RADIUS:    radius_q    <= pwdata[RADIUS_W-1:0];
				REG_MIN_RANGE: min_range_q <= pwdata[RANGE_W-1:0];
				REG_MAX_RANGE: max_range_q <= pwdata[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ROW_X:     prdata = CFG_DATA_W'(row_q[0]);
			REG_ROW_Y:     prdata = CFG_DATA_W'(row_q[1]);
			REG_ROW_Z:     prdata = CFG_DATA_W'(row_q[2]);
			REG_OFFSET:    prdata = CFG_DATA_W'(offset_q);
			REG_RADIUS:    prdata = CFG_DATA_W'(radius_q);
			REG_MIN_RANGE: prdata = CFG_DATA_W'(min_range_q);
			REG_MAX_RANGE: prdata = CFG_DATA_W'(max_range_q);
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage loads when it is empty or its
	// successor loads in the same cycle.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5        = !v_s5 || m_axis_tready;
	assign rdy_s4        = !v_s4 || rdy_s5;
	assign rdy_s3        = !v_s3 || rdy_s4;
	assign rdy_s2        = !v_s2 || rdy_s3;
	assign s_axis_tready = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (s_axis_tready) v_s1 <= s_axis_tvalid;
			if (rdy_s2)        v_s2 <= v_s1;
			if (rdy_s3)        v_s3 <= v_s2;
			if (rdy_s4)        v_s4 <= v_s3;
			if (rdy_s5)        v_s5 <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the nine coefficient products.
	// ------------------------------------------------------------------
	logic signed [C-1:0]      pt_in [3];
	logic signed [PROD_W-1:0] prod_d [3][3];
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic                     fin_s1, last_s1;

	always_comb begin
		logic signed [COEFF_W-1:0] coef;
		for (int r = 0; r < 3; r++) begin
			pt_in[r] = s_axis_tdata[r*C +: C];
		end
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				coef          = row_q[r][k*COEFF_W +: COEFF_W];
				prod_d[r][k]  = PROD_W'(coef) * PROD_W'(pt_in[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			prod_s1 <= prod_d;
			fin_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: row sums with offset and rounding bias.
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0] acc_d [3];
	logic signed [ACC_W-1:0] acc_s2 [3];
	logic                    fin_s2, last_s2;

	always_comb begin
		logic signed [OFFSET_W-1:0] offs;
		for (int r = 0; r < 3; r++) begin
			offs     = offset_q[r*OFFSET_W +: OFFSET_W];
			// Adding half an LSB before the floor shift rounds ties upward.
			acc_d[r] = ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1])
				+ ACC_W'(prod_s1[r][2]) + (ACC_W'(offs) <<< F)
				+ (ACC_W'(1) <<< (F - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			acc_s2  <= acc_d;
			fin_s2  <= fin_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: drop the fraction, saturate, zero the non-finite points.
	// ------------------------------------------------------------------
	logic [C-1:0] q_d [3];
	logic [C-1:0] q_s3 [3];
	logic         fin_s3, last_s3;

	always_comb begin
		logic [SH_W-1:0]    sh;
		logic [SH_W-C:0]    upper;
		for (int r = 0; r < 3; r++) begin
			sh    = acc_s2[r][ACC_W-1:F];
			upper = sh[SH_W-1:C-1];
			if (!fin_s2) begin
				q_d[r] = '0;
			end else if ((&upper) || !(|upper)) begin
				q_d[r] = sh[C-1:0];
			end else if (sh[SH_W-1]) begin
				q_d[r] = {1'b1, {(C-1){1'b0}}};
			end else begin
				q_d[r] = {1'b0, {(C-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			q_s3    <= q_d;
			fin_s3  <= fin_s2;
			last_s3 <= last_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: squares of the levelled coordinates.
	// ------------------------------------------------------------------
	logic [SQ_W-1:0] sq_d [3];
	logic [SQ_W-1:0] sq_s4 [3];
	logic [C-1:0]    q_s4 [3];
	logic            fin_s4, last_s4;

	always_comb begin
		logic signed [SQ_W-1:0] qe;
		for (int r = 0; r < 3; r++) begin
			qe       = SQ_W'(signed'(q_s3[r]));
			sq_d[r]  = qe * qe;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			sq_s4   <= sq_d;
			q_s4    <= q_s3;
			fin_s4  <= fin_s3;
			last_s4 <= last_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: cylinder and range-shell test, output register.
	// ------------------------------------------------------------------
	logic [CMP_W-1:0] h2, r2;
	logic             inside_d;
	logic             inside_s5;
	logic [C-1:0]     q_s5 [3];
	logic             fin_s5, last_s5;

	assign h2       = CMP_W'(sq_s4[0]) + CMP_W'(sq_s4[1]);
	assign r2       = h2 + CMP_W'(sq_s4[2]);
	assign inside_d = fin_s4 && (h2 <= CMP_W'(radius_q))
		&& (r2 >= CMP_W'(min_range_q)) && (r2 <= CMP_W'(max_range_q));

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			inside_s5 <= inside_d;
			q_s5      <= q_s4;
			fin_s5    <= fin_s4;
			last_s5   <= last_s4;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tuser  = inside_s5;
	assign m_axis_tlast  = last_s5;

	generate
		if (PAD_W > 0) begin : g_pad
			assign m_axis_tdata = {{PAD_W{1'b0}}, q_s5[2], q_s5[1], q_s5[0]};
		end else begin : g_nopad
			assign m_axis_tdata = {q_s5[2], q_s5[1], q_s5[0]};
		end
	endgenerate

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A non-finite point is never kept and carries zero coordinates.
	a_nonfinite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !fin_s5) |-> (!inside_s5 && q_s5[0] == '0 && q_s5[1] == '0
			&& q_s5[2] == '0))
		else $error("non-finite point kept or not zeroed");

	// With the output stage empty the whole pipeline can take an item.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// An item in stage four moves to the output stage with its frame mark.
	a_s4_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && rdy_s5) |=> (v_s5 && last_s5 == $past(last_s4)))
		else $error("item lost between stage four and output");

	// A held output item keeps its verdict while the receiver stalls.
	a_hold_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !m_axis_tready) |=> (v_s5 && $stable(inside_s5) && $stable(last_s5)))
		else $error("stalled output item changed");

endmodule

`default_nettype wire

>>> sim/tb_lidar_point_level_and_crop.sv
// Testbench for lidar_point_level_and_crop: streams lidar points through the block, predicts
// the levelled coordinates and the crop decision of each one, and compares every result.
// Depends on lpc_pkg and the lidar_point_level_and_crop RTL; needs nothing else.
module tb_lidar_point_level_and_crop;
	timeunit 1ns;
	timeprecision 1ps;

	import lpc_pkg::*;

	localparam int COORD_BITS   = 19;
	localparam int FRAC_BITS    = 16;
	localparam int DATA_W       = ((3 * COORD_BITS + 7) / 8) * 8;
	localparam int LATENCY      = 5;
	localparam int CLK_PERIOD   = 4;
	localparam int SHOW_LIMIT   = 20;
	localparam int RUN_LIMIT_NS = 2_000_000;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic                  finite;
		logic                  frame_end;
	} point_t;

	typedef struct packed {
		logic                  kept;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic                  last_point;
	} level_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata;  // point_x, point_y, point_z
	logic                  s_axis_tuser;  // point_finite
	logic                  s_axis_tlast;  // frame_end
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [DATA_W-1:0]     m_axis_tdata;  // level_x, level_y, level_z
	logic                  m_axis_tuser;  // inside_res
	logic                  m_axis_tlast;  // last_point
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// Copy of the configuration as the block should hold it.
	logic [ROW_W-1:0]    row_cfg [3];
	logic [OFFS_W-1:0]   offset_cfg;
	logic [RADIUS_W-1:0] radius_cfg;
	logic [RANGE_W-1:0]  min_range_cfg;
	logic [RANGE_W-1:0]  max_range_cfg;

	level_result_t pending_levels[$];

	int  mismatch_count     = 0;
	int  results_seen       = 0;
	int  points_sent        = 0;
	int  kept_count         = 0;
	int  non_finite_count   = 0;
	int  input_stall_cycles = 0;
	int  reg_writes         = 0;
	int  hold_off_left      = 0;
	int  held_cycles        = 0;
	bit  send_steady        = 1'b0;
	bit  sink_steady        = 1'b0;

	lidar_point_level_and_crop dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// One output axis: row times point plus offset, rounded half up and saturated.
	function automatic logic [COORD_BITS-1:0] level_axis(input int axis, input point_t p);
		longint coord [3];
		longint coeff, acc, lo, hi;
		int i;
		coord[0] = $signed(p.x);
		coord[1] = $signed(p.y);
		coord[2] = $signed(p.z);
		acc = 0;
		for (i = 0; i < 3; i++) begin
			coeff = $signed(row_cfg[axis][i*COEFF_W +: COEFF_W]);
			acc = acc + coeff * coord[i];
		end
		coeff = $signed(offset_cfg[axis*OFFSET_W +: OFFSET_W]);
		acc = acc + (coeff <<< FRAC_BITS) + (64'sd1 <<< (FRAC_BITS - 1));
		acc = acc >>> FRAC_BITS;
		lo = -(64'sd1 <<< (COORD_BITS - 1));
		hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
		if (acc < lo)
			acc = lo;
		if (acc > hi)
			acc = hi;
		return acc[COORD_BITS-1:0];
	endfunction

	function automatic level_result_t level_point(input point_t p);
		level_result_t r;
		longint qx, qy, qz, h2, r2;
		r = '0;
		r.last_point = p.frame_end;
		if (p.finite) begin
			r.x = level_axis(0, p);
			r.y = level_axis(1, p);
			r.z = level_axis(2, p);
			qx = $signed(r.x);
			qy = $signed(r.y);
			qz = $signed(r.z);
			h2 = qx * qx + qy * qy;
			r2 = h2 + qz * qz;
			r.kept = (h2 <= longint'(radius_cfg)) && (r2 >= longint'(min_range_cfg))
				&& (r2 <= longint'(max_range_cfg));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= SHOW_LIMIT)
			$display("%0t ns: result %0d mismatch: %s", $time, results_seen, what);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] got, want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Predicts each accepted point and checks each result against the oldest prediction.
	always @(posedge clk) begin : track_points
		level_result_t got, want;
		point_t        seen;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kept       = m_axis_tuser;
				got.x          = m_axis_tdata[COORD_BITS-1:0];
				got.y          = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
				got.z          = m_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
				got.last_point = m_axis_tlast;
				results_seen++;
				if (pending_levels.size() == 0) begin
					report_mismatch("result arrived with no point outstanding");
				end else begin
					want = pending_levels.pop_front();
					kept_count += want.kept;
					check_field("inside_res", got.kept, want.kept);
					check_field("level_x", $signed(got.x), $signed(want.x));
					check_field("level_y", $signed(got.y), $signed(want.y));
					check_field("level_z", $signed(got.z), $signed(want.z));
					check_field("last_point", got.last_point, want.last_point);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen.x         = s_axis_tdata[COORD_BITS-1:0];
				seen.y         = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
				seen.z         = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
				seen.finite    = s_axis_tuser;
				seen.frame_end = s_axis_tlast;
				pending_levels.insert(pending_levels.size(), level_point(seen));
				points_sent++;
				if (!seen.finite)
					non_finite_count++;
			end else if (s_axis_tvalid) begin
				input_stall_cycles++;
			end
		end
	end

	// Gap length for either side: mostly short, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic int small_signed(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Result receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin : result_sink
		int stall_left;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_off_left--;
				held_cycles++;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!sink_steady && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_point(input point_t p);
		if (!send_steady && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(DATA_W - 3 * COORD_BITS){1'b0}}, p.z, p.y, p.x};
		s_axis_tuser  <= p.finite;
		s_axis_tlast  <= p.frame_end;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Waits until every outstanding point has come back and the pipeline is empty.
	// The first edge lets the tracker record an item accepted at the edge just passed.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ROW_X:     row_cfg[0]    = value[ROW_W-1:0];
			REG_ROW_Y:     row_cfg[1]    = value[ROW_W-1:0];
			REG_ROW_Z:     row_cfg[2]    = value[ROW_W-1:0];
			REG_OFFSET:    offset_cfg    = value[OFFS_W-1:0];
			REG_RADIUS:    radius_cfg    = value[RADIUS_W-1:0];
			REG_MIN_RANGE: min_range_cfg = value[RANGE_W-1:0];
			REG_MAX_RANGE: max_range_cfg = value[RANGE_W-1:0];
			default: ;
		endcase
		reg_writes++;
		// Keeps the next setup phase out of this time step.
		@(posedge clk);
	endtask

	task automatic load_config(input logic [ROW_W-1:0] rx, ry, rz,
			input logic [OFFS_W-1:0] offs, input logic [RADIUS_W-1:0] radius,
			input logic [RANGE_W-1:0] min_r, max_r);
		write_reg(REG_ROW_X, rx);
		write_reg(REG_ROW_Y, ry);
		write_reg(REG_ROW_Z, rz);
		write_reg(REG_OFFSET, offs);
		write_reg(REG_RADIUS, radius);
		write_reg(REG_MIN_RANGE, min_r);
		write_reg(REG_MAX_RANGE, max_r);
	endtask

	function automatic logic [ROW_W-1:0] pack_row(input int c0, c1, c2);
		return {c2[COEFF_W-1:0], c1[COEFF_W-1:0], c0[COEFF_W-1:0]};
	endfunction

	function automatic logic [OFFS_W-1:0] pack_offset(input int ox, oy, oz);
		return {oz[OFFSET_W-1:0], oy[OFFSET_W-1:0], ox[OFFSET_W-1:0]};
	endfunction

	function automatic point_t make_point(input int x, y, z, input bit finite, frame_end);
		point_t p;
		p.x         = x[COORD_BITS-1:0];
		p.y         = y[COORD_BITS-1:0];
		p.z         = z[COORD_BITS-1:0];
		p.finite    = finite;
		p.frame_end = frame_end;
		return p;
	endfunction

	function automatic point_t random_point(input bit frame_end);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return make_point(small_signed(3000), small_signed(3000), small_signed(3000),
				$urandom_range(0, 9) != 0, frame_end);
		if (pick < 80)
			return make_point(small_signed(60000), small_signed(60000), small_signed(60000),
				$urandom_range(0, 9) != 0, frame_end);
		return make_point($urandom(), $urandom(), $urandom(), $urandom_range(0, 9) != 0,
			frame_end);
	endfunction

	// A matrix close to a rotation, optionally flipped about y, with a small offset and
	// limits on the scale of the points, so that a good share of points is kept.
	task automatic config_near_level(input bit flip);
		int          diag;
		int unsigned min_sq, max_sq;
		diag   = flip ? -65536 : 65536;
		min_sq = $urandom_range(0, 1_000_000);
		max_sq = min_sq + $urandom_range(0, 40_000_000);
		load_config(pack_row(diag + small_signed(2000), small_signed(6000), small_signed(6000)),
			pack_row(small_signed(6000), 65536 + small_signed(2000), small_signed(6000)),
			pack_row(small_signed(6000), small_signed(6000), diag + small_signed(2000)),
			pack_offset(small_signed(1000), small_signed(1000), small_signed(1000)),
			$urandom_range(0, 9_000_000), min_sq, max_sq);
	endtask

	// Full 64-bit random words, so the bits above each register's width are exercised too.
	task automatic config_full_random();
		write_reg(REG_ROW_X, rand64());
		write_reg(REG_ROW_Y, rand64());
		write_reg(REG_ROW_Z, rand64());
		write_reg(REG_OFFSET, rand64());
		write_reg(REG_RADIUS, rand64());
		write_reg(REG_MIN_RANGE, rand64());
		write_reg(REG_MAX_RANGE, rand64());
	endtask

	task automatic config_extreme(input bit high);
		if (high)
			load_config(pack_row(131071, 131071, 131071), pack_row(131071, 131071, 131071),
				pack_row(131071, 131071, 131071), pack_offset(524287, 524287, 524287),
				'1, '0, '1);
		else
			load_config(pack_row(-131072, -131072, -131072),
				pack_row(-131072, -131072, -131072), pack_row(-131072, -131072, -131072),
				pack_offset(-524288, -524288, -524288), '0, '1, '0);
	endtask

	// Identity after reset: the cylinder and range boundaries, full-scale coordinates
	// and points that are not finite.
	task automatic test_reset_defaults();
		send_point(make_point(0, 0, 0, 1, 0));
		send_point(make_point(2000, 0, 0, 1, 0));
		send_point(make_point(2001, 0, 0, 1, 0));
		send_point(make_point(0, 0, 50000, 1, 0));
		send_point(make_point(0, 0, -50001, 1, 1));
		send_point(make_point(262143, -262144, 262143, 1, 0));
		send_point(make_point(-262144, 262143, -262144, 1, 0));
		send_point(make_point(123, -456, 789, 0, 1));
		send_point(make_point(-262144, -262144, -262144, 0, 0));
		drain_results();
	endtask

	// Half coefficients give exact ties in both signs; a full-scale z row and
	// large offsets push every axis into saturation, the z axis at both ends.
	task automatic test_rounding_saturation();
		load_config(pack_row(32768, 0, 0), pack_row(-32768, 0, 0),
			pack_row(131071, 131071, 131071), pack_offset(0, 0, 0),
			RADIUS_RESET, MIN_RANGE_RESET, MAX_RANGE_RESET);
		send_point(make_point(3, 0, 0, 1, 0));
		send_point(make_point(-3, 0, 0, 1, 0));
		send_point(make_point(1, -1, 1, 1, 0));
		send_point(make_point(-1, 0, 0, 1, 0));
		send_point(make_point(262143, 262143, 262143, 1, 0));
		send_point(make_point(-262144, -262144, -262144, 1, 1));
		drain_results();
		write_reg(REG_OFFSET, pack_offset(524287, -524288, 1));
		send_point(make_point(-262144, 5, 7, 1, 0));
		send_point(make_point(262143, 0, 0, 1, 1));
		drain_results();
	endtask

	// A zero matrix maps every point onto the offset (3, 4, 0), so both squares are 25
	// and the limits can be placed exactly on the point.
	task automatic test_crop_limits();
		point_t p;
		load_config(pack_row(0, 0, 0), pack_row(0, 0, 0), pack_row(0, 0, 0),
			pack_offset(3, 4, 0), 25, 25, 25);
		p = random_point(0);
		p.finite = 1'b1;
		send_point(p);
		send_point(make_point(-262144, 262143, -1, 1, 1));
		drain_results();
		write_reg(REG_RADIUS, 24);
		send_point(make_point(17, -5, 9, 1, 0));
		drain_results();
		// Minimum above maximum: nothing may be kept.
		write_reg(REG_RADIUS, 25);
		write_reg(REG_MIN_RANGE, 26);
		send_point(make_point(0, 0, 0, 1, 1));
		drain_results();
	endtask

	// Random frames under several register settings, with idle and stall patterns
	// changed frame by frame.
	task automatic test_random_frames();
		int phase, n, frame_left;
		frame_left = 0;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0, 4: config_near_level(1'b0);
				1, 7: config_near_level(1'b1);
				2, 5: config_full_random();
				3: config_extreme(1'b1);
				default: config_extreme(1'b0);
			endcase
			for (n = 0; n < 100; n++) begin
				if (frame_left == 0) begin
					frame_left  = $urandom_range(1, 40);
					send_steady = ($urandom_range(0, 3) == 0);
					sink_steady = ($urandom_range(0, 3) == 0);
				end
				frame_left--;
				send_point(random_point(frame_left == 0 || n == 99));
			end
			frame_left  = 0;
			send_steady = 1'b0;
			sink_steady = 1'b0;
			drain_results();
		end
	endtask

	// The receiver holds off long enough for the pipeline to fill while points keep
	// coming, so the input has to stall.
	task automatic test_output_stall();
		int n;
		config_near_level(1'b0);
		send_steady   = 1'b1;
		hold_off_left = 80;
		for (n = 0; n < 30; n++)
			send_point(random_point(n == 29));
		send_steady = 1'b0;
		drain_results();
	endtask

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Run did not finish within %0d ns", RUN_LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : run_tests
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		row_cfg[0]    = ROW_X_RESET;
		row_cfg[1]    = ROW_Y_RESET;
		row_cfg[2]    = ROW_Z_RESET;
		offset_cfg    = OFFSET_RESET;
		radius_cfg    = RADIUS_RESET;
		min_range_cfg = MIN_RANGE_RESET;
		max_range_cfg = MAX_RANGE_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_rounding_saturation();
		test_crop_limits();
		test_output_stall();
		test_random_frames();

		drain_results();
		repeat (LATENCY * 4) @(posedge clk);
		$display("Checked %0d results for %0d points after %0d register writes:",
			results_seen, points_sent, reg_writes,
			" %0d kept, %0d not finite.", kept_count, non_finite_count);
		$display("Receiver held off %0d cycles in one stretch; the input waited %0d cycles in all.",
			held_cycles, input_stall_cycles);
		if (mismatch_count == 0 && pending_levels.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
